### src/mvsp_pkg.sv
package mvsp_pkg;

  localparam int COORD_W     = 10;
  localparam int VALUE_W     = 32;
  localparam int TYPE_W      = 3;
  localparam int ERR_W       = 3;
  localparam int KIND_W      = 2;
  localparam int BYTE_CNT_W  = 9;
  localparam int HEADER_BYTES = 284;
  localparam int HEADER_WORD_BYTES = 28;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;
  localparam int TDATA_W     = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_VOXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_VERSION   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_TYPE      = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd3;
  localparam logic [ERR_W-1:0] ERR_DIM_BIG   = 3'd4;

  localparam logic [TYPE_W-1:0] TYPE_UCHAR = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_INT   = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_FLOAT = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_SHORT = 3'd4;

  localparam logic [2:0] WORD_VERSION = 3'd0;
  localparam logic [2:0] WORD_WIDTH   = 3'd1;
  localparam logic [2:0] WORD_HEIGHT  = 3'd2;
  localparam logic [2:0] WORD_DEPTH   = 3'd3;
  localparam logic [2:0] WORD_TYPE    = 3'd5;

  typedef struct packed {
    kind_t                     kind;
    logic [COORD_W-1:0]        coord_x;
    logic [COORD_W-1:0]        coord_y;
    logic [COORD_W-1:0]        coord_z;
    logic signed [VALUE_W-1:0] voxel_value;
    logic [TYPE_W-1:0]         voxel_type;
    logic [ERR_W-1:0]          error_code;
    logic                      last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

### src/mvsp_value_dec.sv
module mvsp_value_dec (
  input  logic [31:0]                       word,
  input  logic [mvsp_pkg::TYPE_W-1:0]       type_code,
  output logic signed [mvsp_pkg::VALUE_W-1:0] value
);
  import mvsp_pkg::*;

  logic [7:0]  ex;
  logic [22:0] man;
  logic [7:0]  sh;
  logic [31:0] mag;
  logic [31:0] fval;

  assign ex  = word[30:23];
  assign man = word[22:0];
  assign sh  = ex - 8'd127;

  always_comb begin
    mag  = {8'd0, 1'b1, man};
    fval = '0;
    if (ex == 8'hFF && man != '0) begin
      fval = '0;
    end else if (ex < 8'd127) begin
      fval = '0;
    end else if (sh >= 8'd31) begin
      fval = word[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      if (sh >= 8'd23) begin
        mag = mag << 3'(sh - 8'd23);
      end else begin
        mag = mag >> 5'(8'd23 - sh);
      end
      fval = word[31] ? (32'd0 - mag) : mag;
    end
  end

  always_comb begin
    case (type_code)
      TYPE_UCHAR: value = {{24{word[7]}}, word[7:0]};
      TYPE_SHORT: value = {{16{word[15]}}, word[15:0]};
      TYPE_FLOAT: value = fval;
      default:    value = word;
    endcase
  end

endmodule

### src/mvsp_parser.sv
module mvsp_parser #(
  parameter int MAX_DIM = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output mvsp_pkg::result_pair_t results
);
  import mvsp_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_VOX  = 3'b010,
    PH_IDLE = 3'b100
  } phase_t;

  phase_t                  phase, phase_next;
  logic [BYTE_CNT_W-1:0]   byte_count, byte_count_next;
  logic [31:0]             assemble_word, assemble_word_next;
  logic [DIM_W-1:0]        dim_width, dim_width_next;
  logic [DIM_W-1:0]        dim_height, dim_height_next;
  logic [DIM_W-1:0]        dim_depth, dim_depth_next;
  logic [TYPE_W-1:0]       type_code, type_code_next;
  logic [DIM_W-1:0]        x_counter, x_counter_next;
  logic [DIM_W-1:0]        y_counter, y_counter_next;
  logic [DIM_W-1:0]        z_counter, z_counter_next;
  logic [1:0]              voxel_byte_index, voxel_byte_index_next;

  logic [31:0]             word_in;
  logic                    dim_neg;
  logic                    dim_big;
  logic [DIM_W-1:0]        dim_val;
  logic [2:0]              idx;
  logic [2:0]              bytes_per_voxel;
  logic [DIM_W:0]          x_inc, y_inc, z_inc;
  logic signed [VALUE_W-1:0] dec_value;
  logic [ERR_W-1:0]        err;
  logic                    prim_vld;
  result_t                 prim;
  logic                    trunc_vld;
  result_t                 trunc;

  assign word_in = {assemble_word[23:0], in_byte};
  assign dim_neg = word_in[31];
  assign dim_big = !dim_neg && (word_in > 32'(MAX_DIM));
  assign dim_val = (dim_neg || dim_big) ? '0 : word_in[DIM_W-1:0];
  assign idx     = {1'b0, voxel_byte_index} + 3'd1;
  assign x_inc   = {1'b0, x_counter} + 1'b1;
  assign y_inc   = {1'b0, y_counter} + 1'b1;
  assign z_inc   = {1'b0, z_counter} + 1'b1;

  always_comb begin
    case (type_code)
      TYPE_UCHAR: bytes_per_voxel = 3'd1;
      TYPE_SHORT: bytes_per_voxel = 3'd2;
      default:    bytes_per_voxel = 3'd4;
    endcase
  end

  mvsp_value_dec u_value_dec (
    .word      (word_in),
    .type_code (type_code),
    .value     (dec_value)
  );

  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    assemble_word_next    = assemble_word;
    dim_width_next        = dim_width;
    dim_height_next       = dim_height;
    dim_depth_next        = dim_depth;
    type_code_next        = type_code;
    x_counter_next        = x_counter;
    y_counter_next        = y_counter;
    z_counter_next        = z_counter;
    voxel_byte_index_next = voxel_byte_index;
    err                   = ERR_NONE;
    prim_vld              = 1'b0;
    prim                  = '0;

    unique case (phase)
      PH_HEAD: begin
        assemble_word_next = word_in;
        byte_count_next    = byte_count + 1'b1;
        if (byte_count < BYTE_CNT_W'(HEADER_WORD_BYTES) && byte_count[1:0] == 2'd3) begin
          case (byte_count[4:2])
            WORD_VERSION: if (word_in == '0) err = ERR_VERSION;
            WORD_WIDTH: begin
              dim_width_next = dim_val;
              if (dim_big) err = ERR_DIM_BIG;
            end
            WORD_HEIGHT: begin
              dim_height_next = dim_val;
              if (dim_big) err = ERR_DIM_BIG;
            end
            WORD_DEPTH: begin
              dim_depth_next = dim_val;
              if (dim_big) err = ERR_DIM_BIG;
            end
            WORD_TYPE: begin
              if (word_in == 32'(TYPE_UCHAR) || word_in == 32'(TYPE_INT) ||
                  word_in == 32'(TYPE_FLOAT) || word_in == 32'(TYPE_SHORT)) begin
                type_code_next = word_in[TYPE_W-1:0];
              end else begin
                err = ERR_TYPE;
              end
            end
            default: ;
          endcase
        end else if (byte_count == BYTE_CNT_W'(HEADER_BYTES - 1)) begin
          prim_vld              = 1'b1;
          prim.kind             = KIND_HEADER;
          prim.voxel_type       = type_code;
          assemble_word_next    = '0;
          voxel_byte_index_next = '0;
          x_counter_next        = '0;
          y_counter_next        = '0;
          z_counter_next        = '0;
          if (dim_width == '0 || dim_height == '0 || dim_depth == '0) begin
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_VOX;
          end
        end
        if (err != ERR_NONE) begin
          prim_vld        = 1'b1;
          prim.kind       = KIND_ERROR;
          prim.error_code = err;
          phase_next      = PH_IDLE;
        end
      end
      PH_VOX: begin
        assemble_word_next = word_in;
        if (idx >= bytes_per_voxel) begin
          prim_vld              = 1'b1;
          prim.kind             = KIND_VOXEL;
          prim.coord_x          = COORD_W'(x_counter);
          prim.coord_y          = COORD_W'(y_counter);
          prim.coord_z          = COORD_W'(z_counter);
          prim.voxel_value      = dec_value;
          prim.voxel_type       = type_code;
          voxel_byte_index_next = '0;
          assemble_word_next    = '0;
          x_counter_next        = x_inc[DIM_W-1:0];
          if (x_inc >= {1'b0, dim_width}) begin
            x_counter_next = '0;
            y_counter_next = y_inc[DIM_W-1:0];
            if (y_inc >= {1'b0, dim_height}) begin
              y_counter_next = '0;
              z_counter_next = z_inc[DIM_W-1:0];
              if (z_inc >= {1'b0, dim_depth}) phase_next = PH_IDLE;
            end
          end
        end else begin
          voxel_byte_index_next = idx[1:0];
        end
      end
      PH_IDLE: ;
      default: ;
    endcase

    trunc_vld        = in_last && (phase_next != PH_IDLE);
    trunc            = '0;
    trunc.kind       = KIND_ERROR;
    trunc.error_code = ERR_TRUNCATED;
  end

  always_comb begin
    results        = '0;
    results.count  = {1'b0, prim_vld} + {1'b0, trunc_vld};
    results.first  = prim_vld ? prim : trunc;
    results.first.last_of_run = !(prim_vld && trunc_vld);
    results.second = trunc;
    results.second.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && in_last)) begin
      phase            <= PH_HEAD;
      byte_count       <= '0;
      assemble_word    <= '0;
      dim_width        <= '0;
      dim_height       <= '0;
      dim_depth        <= '0;
      type_code        <= '0;
      x_counter        <= '0;
      y_counter        <= '0;
      z_counter        <= '0;
      voxel_byte_index <= '0;
    end else if (take) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      assemble_word    <= assemble_word_next;
      dim_width        <= dim_width_next;
      dim_height       <= dim_height_next;
      dim_depth        <= dim_depth_next;
      type_code        <= type_code_next;
      x_counter        <= x_counter_next;
      y_counter        <= y_counter_next;
      z_counter        <= z_counter_next;
      voxel_byte_index <= voxel_byte_index_next;
    end
  end

endmodule

### src/mvsp_out_fifo.sv
module mvsp_out_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  mvsp_pkg::result_pair_t            pair,
  input  logic                              pop,
  output mvsp_pkg::result_t                 head,
  output logic                              not_empty,
  output logic [mvsp_pkg::FIFO_CNT_W-1:0]   count
);
  import mvsp_pkg::*;

  result_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [1:0]            n_push;

  assign n_push    = push ? pair.count : 2'd0;
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem[wr_ptr] <= pair.first;
    if (n_push == 2'd2) mem[wr_ptr + 1'b1] <= pair.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    end
  end

endmodule

### src/mgh_volume_stream_parser_unit.sv
// channel  | signals                           | carries
// s_axis   | tvalid tready tdata[7:0] tlast     | one file byte, tlast on the final byte
// m_axis   | tvalid tready tdata[71:0] tuser    | one result, tlast on the final one of a byte
//          | tlast                              |
// one byte per cycle while the queue has room; a byte is held in the input register,
// then its zero to two results go into a four-entry output queue and show the next cycle
// the input register is taken only with two free queue slots, one of them may be freed
// by a pop in that cycle, so a stalled output holds input after the queue fills
// rst is synchronous; a byte with tlast also returns the parser to its start
module mgh_volume_stream_parser_unit #(
  parameter int MAX_DIM = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // coord_x, coord_y, coord_z, voxel_value, voxel_type, error_code, zero fill
  output logic [mvsp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [mvsp_pkg::KIND_W-1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last_of_run
);
  import mvsp_pkg::*;

  logic                  in_vld;
  logic [7:0]            in_byte;
  logic                  in_last;
  logic                  take;
  logic                  pop;
  logic                  q_not_empty;
  logic [FIFO_CNT_W-1:0] q_count;
  result_t               q_head;
  result_pair_t          results;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign take          = in_vld && (q_count <= FIFO_CNT_W'(2) ||
                                    (q_count == FIFO_CNT_W'(3) && pop));
  assign s_axis_tready = !in_vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  mvsp_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (in_byte),
    .in_last (in_last),
    .results (results)
  );

  mvsp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .pair      (results),
    .pop       (pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign m_axis_tvalid = q_not_empty;
  assign m_axis_tdata  = {4'd0, q_head.error_code, q_head.voxel_type, q_head.voxel_value,
                          q_head.coord_z, q_head.coord_y, q_head.coord_x};
  assign m_axis_tuser  = q_head.kind;
  assign m_axis_tlast  = q_head.last_of_run;

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output queue count beyond depth");

  a_take_room: assert property (@(posedge clk) disable iff (rst)
    take |=> q_count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("byte taken without room for its results");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_ERROR) |-> q_head.error_code != ERR_NONE)
    else $error("error result without a code");

  a_voxel_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != KIND_ERROR) |-> q_head.error_code == ERR_NONE)
    else $error("non-error result carries an error code");
`endif

endmodule

### test/mgh_volume_stream_parser_unit_tb.sv
module mgh_volume_stream_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mvsp_pkg::*;

  localparam int MAX_DIM = 1024;
  localparam int CYCLE_LIMIT = 300_000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {
    SCAN_HEADER,
    SCAN_VOXELS,
    SCAN_DONE
  } scan_phase_t;

  class volume_scoreboard;
    scan_phase_t       phase;
    int                byte_count;
    logic [31:0]       word;
    int                dim_w, dim_h, dim_d;
    logic [TYPE_W-1:0] vtype;
    int                x, y, z;
    int                vbyte;
    int                checked;
    result_t           pending_results[$];

    function new();
      restart();
      checked = 0;
    endfunction

    function void restart();
      phase = SCAN_HEADER;
      byte_count = 0;
      word = '0;
      dim_w = 0;
      dim_h = 0;
      dim_d = 0;
      vtype = TYPE_UCHAR;
      x = 0;
      y = 0;
      z = 0;
      vbyte = 0;
    endfunction

    // negative reads as zero, oversize flags an error
    function int dim_value(logic [31:0] w, output bit too_big);
      too_big = 1'b0;
      if (w[31]) return 0;
      if (w > MAX_DIM) begin
        too_big = 1'b1;
        return 0;
      end
      return int'(w);
    endfunction

    function int voxel_bytes(logic [TYPE_W-1:0] t);
      if (t == TYPE_UCHAR) return 1;
      if (t == TYPE_SHORT) return 2;
      return 4;
    endfunction

    // truncate toward zero, saturate, nan to zero
    function logic [31:0] float_to_int(logic [31:0] f);
      int unsigned e;
      logic [31:0] mag;
      e = f[30:23];
      if (e == 255 && f[22:0] != '0) return '0;
      if (e < 127) return '0;
      if (e - 127 >= 31) return f[31] ? 32'h8000_0000 : 32'h7fff_ffff;
      mag = {8'h00, 1'b1, f[22:0]};
      if (e - 127 >= 23) mag = mag << (e - 150);
      else mag = mag >> (150 - e);
      return f[31] ? -mag : mag;
    endfunction

    function logic [31:0] decode(logic [31:0] w);
      if (vtype == TYPE_UCHAR) return {{24{w[7]}}, w[7:0]};
      if (vtype == TYPE_SHORT) return {{16{w[15]}}, w[15:0]};
      if (vtype == TYPE_FLOAT) return float_to_int(w);
      return w;
    endfunction

    function result_t make_result(kind_t k, int cx, int cy, int cz, logic [31:0] v,
                                  logic [TYPE_W-1:0] t, logic [ERR_W-1:0] e);
      result_t r;
      r.kind = k;
      r.coord_x = cx[COORD_W-1:0];
      r.coord_y = cy[COORD_W-1:0];
      r.coord_z = cz[COORD_W-1:0];
      r.voxel_value = v;
      r.voxel_type = t;
      r.error_code = e;
      r.last_of_run = 1'b0;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      result_t          caused[2];
      int               n;
      logic [ERR_W-1:0] err;
      bit               big;
      n = 0;
      err = ERR_NONE;
      big = 1'b0;
      if (phase == SCAN_HEADER) begin
        word = {word[23:0], b};
        if (byte_count < HEADER_WORD_BYTES && byte_count % 4 == 3) begin
          case (byte_count / 4)
            WORD_VERSION: if (word == '0) err = ERR_VERSION;
            WORD_WIDTH:   dim_w = dim_value(word, big);
            WORD_HEIGHT:  dim_h = dim_value(word, big);
            WORD_DEPTH:   dim_d = dim_value(word, big);
            WORD_TYPE: begin
              if (word == TYPE_UCHAR || word == TYPE_INT || word == TYPE_FLOAT ||
                  word == TYPE_SHORT) vtype = word[TYPE_W-1:0];
              else err = ERR_TYPE;
            end
            default: ;
          endcase
          if (big) err = ERR_DIM_BIG;
        end else if (byte_count == HEADER_BYTES - 1) begin
          caused[n] = make_result(KIND_HEADER, 0, 0, 0, '0, vtype, ERR_NONE);
          n++;
          word = '0;
          vbyte = 0;
          x = 0;
          y = 0;
          z = 0;
          phase = (dim_w == 0 || dim_h == 0 || dim_d == 0) ? SCAN_DONE : SCAN_VOXELS;
        end
        byte_count++;
        if (err != ERR_NONE) begin
          caused[n] = make_result(KIND_ERROR, 0, 0, 0, '0, '0, err);
          n++;
          phase = SCAN_DONE;
        end
      end else if (phase == SCAN_VOXELS) begin
        word = {word[23:0], b};
        if (vbyte + 1 >= voxel_bytes(vtype)) begin
          caused[n] = make_result(KIND_VOXEL, x, y, z, decode(word), vtype, ERR_NONE);
          n++;
          vbyte = 0;
          word = '0;
          x++;
          if (x >= dim_w) begin
            x = 0;
            y++;
            if (y >= dim_h) begin
              y = 0;
              z++;
              if (z >= dim_d) phase = SCAN_DONE;
            end
          end
        end else begin
          vbyte++;
        end
      end
      if (last) begin
        if (phase != SCAN_DONE) begin
          caused[n] = make_result(KIND_ERROR, 0, 0, 0, '0, '0, ERR_TRUNCATED);
          n++;
        end
        restart();
      end
      if (n > 0) caused[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) pending_results.push_back(caused[i]);
    endfunction

    // empty string when the result matches the oldest expectation
    function string check_result(logic [TDATA_W-1:0] d, logic [KIND_W-1:0] k, logic l);
      result_t want;
      string   msg;
      msg = "";
      if (pending_results.size() == 0)
        return $sformatf("result kind %0d with nothing pending", k);
      want = pending_results.pop_front();
      checked++;
      if (k != want.kind) msg = {msg, $sformatf(" kind %0d/%0d", k, want.kind)};
      if (d[9:0] != want.coord_x)
        msg = {msg, $sformatf(" x %0d/%0d", d[9:0], want.coord_x)};
      if (d[19:10] != want.coord_y)
        msg = {msg, $sformatf(" y %0d/%0d", d[19:10], want.coord_y)};
      if (d[29:20] != want.coord_z)
        msg = {msg, $sformatf(" z %0d/%0d", d[29:20], want.coord_z)};
      if (d[61:30] != want.voxel_value)
        msg = {msg, $sformatf(" value %h/%h", d[61:30], want.voxel_value)};
      if (d[64:62] != want.voxel_type)
        msg = {msg, $sformatf(" type %0d/%0d", d[64:62], want.voxel_type)};
      if (d[67:65] != want.error_code)
        msg = {msg, $sformatf(" error %0d/%0d", d[67:65], want.error_code)};
      if (l != want.last_of_run)
        msg = {msg, $sformatf(" last %0d/%0d", l, want.last_of_run)};
      if (msg != "") msg = $sformatf("result %0d got/want:%s", checked, msg);
      return msg;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [KIND_W-1:0]   m_axis_tuser;
  logic                m_axis_tlast;

  volume_scoreboard sb;
  logic [7:0]  file_q[$];
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;

  mgh_volume_stream_parser_unit #(.MAX_DIM(MAX_DIM)) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mgh_volume_stream_parser_unit verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    string msg;
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      msg = sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (msg != "") report_mismatch(msg);
    end
  end

  // result sink with random stalls
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // sends the first keep bytes of the file, marking the final one
  task automatic send_file(int keep);
    src_steady = ($urandom_range(0, 4) == 0);
    sink_steady = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < keep; i++) send_byte(file_q[i], i == keep - 1);
  endtask

  task automatic push_word(logic [31:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) file_q.push_back(v[8*i +: 8]);
  endtask

  task automatic build_header(logic [31:0] ver, logic [31:0] wid, logic [31:0] hgt,
                              logic [31:0] dep, logic [31:0] type_word);
    file_q.delete();
    push_word(ver, 4);
    push_word(wid, 4);
    push_word(hgt, 4);
    push_word(dep, 4);
    push_word($urandom(), 4);
    push_word(type_word, 4);
    push_word($urandom(), 4);
    repeat (HEADER_BYTES - HEADER_WORD_BYTES) file_q.push_back(8'($urandom()));
  endtask

  initial begin
    logic [31:0] float_cases[$];
    sb = new();
    float_cases = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbfc0_0000,
                    32'h3f00_0000, 32'h4eff_ffff, 32'h4f00_0000, 32'hcf00_0000,
                    32'hcf80_0000, 32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000,
                    32'h4b00_0001, 32'h4aff_ffff, 32'h0000_0001, 32'hffff_ffff};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero version, then the same ending on the version word
    build_header(0, 2, 2, 2, TYPE_UCHAR);
    send_file(8);
    send_file(4);
    // unsupported type words
    build_header(1, 1, 1, 1, 2);
    send_file(30);
    build_header(1, 1, 1, 1, 32'hffff_ffff);
    send_file(24);
    // oversize dimensions, one ending on its own word
    build_header(1, MAX_DIM + 1, 1, 1, TYPE_UCHAR);
    send_file(12);
    build_header(1, 1, 32'h7fff_ffff, 1, TYPE_UCHAR);
    send_file(12);
    build_header(1, 1, 1, 2000, TYPE_UCHAR);
    send_file(20);
    // negative width gives an empty volume
    build_header(1, 32'h8000_0007, 3, 3, TYPE_INT);
    file_q.push_back(8'($urandom()));
    send_file(file_q.size());
    // char extremes, bytes after the frame ignored
    build_header(7, 3, 1, 1, TYPE_UCHAR);
    push_word(32'h007f_80ff, 3);
    repeat (2) file_q.push_back(8'($urandom()));
    send_file(file_q.size());
    // short extremes
    build_header(1, 2, 1, 1, TYPE_SHORT);
    push_word(32'h8000, 2);
    push_word(32'h7fff, 2);
    send_file(file_q.size());
    // early ends: on the first byte, right after a full int voxel
    send_file(1);
    build_header(1, 2, 2, 1, TYPE_INT);
    push_word(32'h8000_0000, 4);
    push_word(32'hffff_ffff, 4);
    send_file(HEADER_BYTES + 4);
    // float conversions over a volume that walks all three axes
    build_header(1, 2, 2, 4, TYPE_FLOAT);
    foreach (float_cases[i]) push_word(float_cases[i], 4);
    send_file(file_q.size());
    s_axis_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mgh_volume_stream_parser_unit verification clean");
    end else begin
      $display("mgh_volume_stream_parser_unit verification failed");
    end
    $finish;
  end

endmodule
